### rtl/sss_pkg.sv
package sss_pkg;

    localparam int DEFAULT_DIGITS = 6;

    localparam int TICKS_W   = 10;
    localparam int POINT_W   = 3;
    localparam int CFG_W     = 10;
    localparam int SEG_W     = 8;
    localparam int SEL_W     = 6;
    localparam int ELAPSED_W = 20;
    localparam int BCD_W     = 4;
    localparam int POS_W     = 3;

    localparam logic [TICKS_W-1:0] TICKS_RESET = 10'd10;
    localparam logic [POINT_W-1:0] POINT_RESET = 3'd2;
    localparam logic [BCD_W-1:0]   DIGIT_MAX   = 4'd9;

    typedef enum logic [1:0] {
        KEY_NONE  = 2'd0,
        KEY_START = 2'd1,
        KEY_STOP  = 2'd2,
        KEY_RESET = 2'd3
    } key_t;

    typedef enum logic {
        REG_TICKS_PER_COUNT = 1'b0,
        REG_POINT_DIGIT     = 1'b1
    } cfg_reg_t;

    function automatic logic [SEG_W-1:0] seg_font(input logic [BCD_W-1:0] d);
        logic [SEG_W-1:0] f;
        case (d)
            4'd0:    f = 8'h3F;
            4'd1:    f = 8'h06;
            4'd2:    f = 8'h5B;
            4'd3:    f = 8'h4F;
            4'd4:    f = 8'h66;
            4'd5:    f = 8'h6D;
            4'd6:    f = 8'h7D;
            4'd7:    f = 8'h07;
            4'd8:    f = 8'h7F;
            4'd9:    f = 8'h67;
            default: f = 8'h3F;
        endcase
        return f;
    endfunction

endpackage

### rtl/stopwatch_segment_scan_unit.sv
// Channel  Direction  Handshake             Payload
// input    in         in_valid / in_stall   ms_tick, key
// output   out        out_valid / out_stall segments, digit_select, elapsed, running
// config   in         cfg_write             cfg_index, cfg_data
//
// Key handling, prescaler, decimal carry chain and font lookup sit between the state
// registers and the output register.
// A new input transaction is taken every cycle unless a result waits under out_stall.
// After rst_n the stopwatch is stopped at zero, scan at position zero, registers at
// their defaults; no clearing pass is needed.
// The input stalls only while the output register holds a result that is stalled.
module stopwatch_segment_scan_unit
#(
    parameter int DIGITS = sss_pkg::DEFAULT_DIGITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          ms_tick,
    input  logic [1:0]                    key,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sss_pkg::SEG_W-1:0]     segments,
    output logic [sss_pkg::SEL_W-1:0]     digit_select,
    output logic [sss_pkg::ELAPSED_W-1:0] elapsed,
    output logic                          running,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [sss_pkg::CFG_W-1:0]     cfg_data
);
    import sss_pkg::*;

    localparam int unsigned COUNT_MOD = 10 ** DIGITS;
    localparam int CNT_W = $clog2(COUNT_MOD);

    logic [TICKS_W-1:0] ticks_reg;
    logic [POINT_W-1:0] point_reg;
    logic [BCD_W-1:0]   digit_reg [DIGITS];
    logic [BCD_W-1:0]   digit_next [DIGITS];
    logic [CNT_W-1:0]   bin_reg;
    logic [CNT_W-1:0]   bin_next;
    logic [TICKS_W-1:0] sub_reg;
    logic [TICKS_W-1:0] sub_next;
    logic               run_reg;
    logic               run_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic               out_valid_reg;
    logic [SEG_W-1:0]   segments_reg;
    logic [SEG_W-1:0]   segments_next;
    logic [SEL_W-1:0]   select_reg;
    logic [SEL_W-1:0]   select_next;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic               running_reg;

    logic               accept;
    logic               clr;
    logic [TICKS_W-1:0] sub_key;
    logic [TICKS_W-1:0] limit;
    logic               step;
    logic               carry;
    logic [BCD_W-1:0]   base;
    logic [CNT_W-1:0]   bin_base;
    logic [POS_W:0]     pos_sum;
    logic [BCD_W-1:0]   shown;
    logic [31:0]        bin_wide;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        run_next = run_reg;
        sub_key  = sub_reg;
        clr      = 1'b0;
        case (key_t'(key))
            KEY_START:
            begin
                run_next = 1'b1;
            end
            KEY_STOP:
            begin
                if (run_reg)
                begin
                    run_next = 1'b0;
                    sub_key  = '0;
                end
            end
            KEY_RESET:
            begin
                clr      = 1'b1;
                sub_key  = '0;
                run_next = 1'b1;
            end
            default:
            begin
            end
        endcase

        limit = (ticks_reg == '0) ? TICKS_W'(1) : ticks_reg;
        step  = ms_tick && run_next
                && (({1'b0, sub_key} + (TICKS_W+1)'(1)) >= {1'b0, limit});
        if (ms_tick && run_next)
        begin
            sub_next = step ? '0 : sub_key + TICKS_W'(1);
        end
        else
        begin
            sub_next = sub_key;
        end

        carry = step;
        for (int i = 0; i < DIGITS; i++)
        begin
            base = clr ? '0 : digit_reg[i];
            if (carry)
            begin
                digit_next[i] = (base == DIGIT_MAX) ? '0 : base + BCD_W'(1);
            end
            else
            begin
                digit_next[i] = base;
            end
            carry = carry && (base == DIGIT_MAX);
        end

        bin_base = clr ? '0 : bin_reg;
        if (step)
        begin
            bin_next = carry ? '0 : bin_base + CNT_W'(1);
        end
        else
        begin
            bin_next = bin_base;
        end

        pos_sum = {1'b0, pos_reg} + (POS_W+1)'(1);
        if (ms_tick)
        begin
            pos_next = (pos_sum >= (POS_W+1)'(DIGITS)) ? '0 : pos_sum[POS_W-1:0];
        end
        else
        begin
            pos_next = pos_reg;
        end

        shown = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (pos_next == POS_W'(i))
            begin
                shown = digit_next[i];
            end
        end
        segments_next = seg_font(shown);
        if ((pos_next == point_reg) && ({1'b0, point_reg} < (POINT_W+1)'(DIGITS)))
        begin
            segments_next[SEG_W-1] = 1'b1;
        end

        for (int i = 0; i < SEL_W; i++)
        begin
            select_next[i] = (pos_next != POS_W'(i));
        end

        bin_wide = 32'(bin_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= TICKS_RESET;
            point_reg <= POINT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TICKS_PER_COUNT: ticks_reg <= cfg_data[TICKS_W-1:0];
                REG_POINT_DIGIT:     point_reg <= cfg_data[POINT_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                digit_reg[i] <= '0;
            end
            bin_reg       <= '0;
            sub_reg       <= '0;
            run_reg       <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                for (int i = 0; i < DIGITS; i++)
                begin
                    digit_reg[i] <= digit_next[i];
                end
                bin_reg       <= bin_next;
                sub_reg       <= sub_next;
                run_reg       <= run_next;
                pos_reg       <= pos_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            segments_reg <= segments_next;
            select_reg   <= select_next;
            elapsed_reg  <= bin_wide[ELAPSED_W-1:0];
            running_reg  <= run_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign segments     = segments_reg;
    assign digit_select = select_reg;
    assign elapsed      = elapsed_reg;
    assign running      = running_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (running == run_reg))
        else $error("Running flag in the result does not match the run state.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !run_reg |-> (sub_reg == '0))
        else $error("Sub-count is not zero while stopped.");

    assert property (@(posedge clk) disable iff (!rst_n)
        32'(bin_reg) < COUNT_MOD)
        else $error("Binary count went past the largest decimal count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(elapsed)))
        else $error("A stalled result was dropped or changed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, pos_reg} < (POS_W+1)'(DIGITS)))
        else $error("Scan position is outside the display.");

endmodule
